### design/sight_cone_grid_ray_check_top_defines.svh
// ----------------------------------------------------------------------------
// sight cone grid ray check assertion macros
// Shared property shapes for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef SIGHT_CONE_GRID_RAY_CHECK_TOP_DEFINES_SVH
`define SIGHT_CONE_GRID_RAY_CHECK_TOP_DEFINES_SVH

// same-cycle implication, off while reset is held
`define SCGR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while reset is held
`define SCGR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/scgr_pkg.sv
// ----------------------------------------------------------------------------
// scgr_pkg
// Sizes, codes and the queued request format of the sight cone grid ray check.
// ----------------------------------------------------------------------------
package scgr_pkg;

  // grid and coordinate sizes
  localparam int GRID_COLS  = 64;
  localparam int GRID_ROWS  = 64;
  localparam int COORD_BITS = 16;

  // fixed port widths
  localparam int CELL_W     = 6;
  localparam int CRD_IN_W   = 16;
  localparam int TS_W       = 4;
  localparam int TAN_W      = 16;
  localparam int TAN_FRAC   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // derived widths
  localparam int CRD_W     = (COORD_BITS < CRD_IN_W) ? COORD_BITS : CRD_IN_W;
  localparam int MIN_SHIFT = 4;
  localparam int CI_W      = CRD_W - MIN_SHIFT;
  localparam int COL_AW    = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
  localparam int ROW_AW    = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
  localparam int DY_W      = CRD_W + 1;
  // largest tile edge is 2**(2**TS_W - 1)
  localparam int AX0_W     = 2 ** TS_W;
  localparam int TW        = AX0_W + 1;
  localparam int AX_W      = ((CRD_W > AX0_W) ? CRD_W : AX0_W) + 2;
  localparam int PROD_W    = AX_W + CRD_W;
  localparam int MA_W      = ((TAN_W > AX0_W) ? TAN_W : AX0_W) + 1;
  localparam int MB_W      = CRD_W + 1;
  localparam int MP_W      = MA_W + MB_W;

  // request queue
  localparam int QDEPTH = 2;
  localparam int QA_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  // command codes
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TILE_SHIFT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAN_LOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TAN_HIGH   = 2'd2;

  // reset values
  localparam logic [TS_W-1:0]         TILE_SHIFT_RST = 4'd9;
  localparam logic signed [TAN_W-1:0] TAN_LOW_RST    = -16'sd256;
  localparam logic signed [TAN_W-1:0] TAN_HIGH_RST   = 16'sd256;

  typedef enum logic [1:0] {
    ST_SEEN    = 2'd0,
    ST_BEHIND  = 2'd1,
    ST_OUTCONE = 2'd2,
    ST_BLOCKED = 2'd3
  } status_t;

  // classified request passed from front to back
  typedef struct packed {
    logic                     is_query;
    logic                     wr_ok;
    logic                     wr_occ;
    logic [COL_AW-1:0]        wr_col;
    logic [ROW_AW-1:0]        wr_row;
    logic                     early;
    status_t                  early_status;
    logic                     need_cone;
    logic [DY_W-1:0]          dy;
    logic [CRD_W-1:0]         adx;
    logic [CRD_W-1:0]         ady;
    logic                     x_neg;
    logic                     y_neg;
    logic [CI_W-1:0]          i0;
    logic [CI_W-1:0]          j0;
    logic [CI_W-1:0]          iend;
    logic [CI_W-1:0]          jend;
    logic [AX0_W-1:0]         ax0;
    logic [AX0_W-1:0]         ay0;
    logic [TS_W-1:0]          shift;
  } req_t;

endpackage

### design/sight_cone_grid_ray_check_top.sv
// ----------------------------------------------------------------------------
// sight_cone_grid_ray_check_top
// Line-of-sight checker over a one-bit occupancy grid.
// ----------------------------------------------------------------------------
// A request either writes one grid cell or asks whether a target is seen from
// a source facing left or right. The input side takes one request per cycle
// into a two-entry queue, stalling while it is full; the back end then works
// one request at a time. A cell write occupies the back end for a row read
// and a merged row write. A query rejected for facing or a vertical offset
// goes straight to the output register; a cone reject first checks the cone
// products of the shared multiplier. A query that reaches the walk runs the
// cone test (skipped when source and target are the same point), forms the
// tile boundary products, then visits at most |iend - i0| + |jend - j0| + 1
// cells with one grid row read per cycle, then loads the output register. A
// stalled result holds the back end until it is taken. No clearing pass is
// needed after reset: a row never written reads as clear.
// ----------------------------------------------------------------------------
`include "sight_cone_grid_ray_check_top_defines.svh"

module sight_cone_grid_ray_check_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [scgr_pkg::CELL_W-1:0]           in_cell_col,
  input  logic [scgr_pkg::CELL_W-1:0]           in_cell_row,
  input  logic                                  in_occupied,
  input  logic [scgr_pkg::CRD_IN_W-1:0]         in_src_x,
  input  logic [scgr_pkg::CRD_IN_W-1:0]         in_src_y,
  input  logic [scgr_pkg::CRD_IN_W-1:0]         in_tgt_x,
  input  logic [scgr_pkg::CRD_IN_W-1:0]         in_tgt_y,
  input  logic                                  in_facing_left,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_visible,
  output logic [1:0]                            out_status,
  // configuration
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [scgr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [scgr_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [scgr_pkg::TS_W-1:0]          tile_shift_r;
  logic signed [scgr_pkg::TAN_W-1:0]  tan_low_r, tan_high_r;
  scgr_pkg::req_t                     front_req, q_head;
  logic                               q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_shift_r <= scgr_pkg::TILE_SHIFT_RST;
      tan_low_r    <= scgr_pkg::TAN_LOW_RST;
      tan_high_r   <= scgr_pkg::TAN_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scgr_pkg::CFG_TILE_SHIFT: tile_shift_r <= cfg_data[scgr_pkg::TS_W-1:0];
        scgr_pkg::CFG_TAN_LOW:    tan_low_r    <= cfg_data[scgr_pkg::TAN_W-1:0];
        scgr_pkg::CFG_TAN_HIGH:   tan_high_r   <= cfg_data[scgr_pkg::TAN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request classification
  scgr_front u_front (
    .cmd         (in_cmd),
    .cell_col    (in_cell_col),
    .cell_row    (in_cell_row),
    .occupied    (in_occupied),
    .src_x       (in_src_x),
    .src_y       (in_src_y),
    .tgt_x       (in_tgt_x),
    .tgt_y       (in_tgt_y),
    .facing_left (in_facing_left),
    .tile_shift  (tile_shift_r),
    .req         (front_req)
  );

  // decoupling queue
  scgr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (in_valid),
    .push_req (front_req),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // execution
  scgr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_head      (q_head),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .tan_low     (tan_low_r),
    .tan_high    (tan_high_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_visible (out_visible),
    .out_status  (out_status)
  );

  // checks
  `SCGR_ASSERT_NOW(a_vis_matches_status, out_valid, out_visible == (out_status == scgr_pkg::ST_SEEN), "visible flag disagrees with status")
  `SCGR_ASSERT_NOW(a_queue_level, 1'b1, !(q_full && q_empty), "queue reports full and empty")
  `SCGR_ASSERT_NEXT(a_push_lands, in_valid && !in_stall && q_empty, !q_empty, "accepted request lost")

endmodule

### design/scgr_front.sv
// ----------------------------------------------------------------------------
// scgr_front
// Classifies an incoming request: grid write, early reject, or ray walk setup.
// ----------------------------------------------------------------------------
module scgr_front (
  input  logic                               cmd,
  input  logic [scgr_pkg::CELL_W-1:0]        cell_col,
  input  logic [scgr_pkg::CELL_W-1:0]        cell_row,
  input  logic                               occupied,
  input  logic [scgr_pkg::CRD_IN_W-1:0]      src_x,
  input  logic [scgr_pkg::CRD_IN_W-1:0]      src_y,
  input  logic [scgr_pkg::CRD_IN_W-1:0]      tgt_x,
  input  logic [scgr_pkg::CRD_IN_W-1:0]      tgt_y,
  input  logic                               facing_left,
  input  logic [scgr_pkg::TS_W-1:0]          tile_shift,
  output scgr_pkg::req_t                     req
);

  logic [scgr_pkg::CRD_W-1:0] xs, ys, xt, yt;
  logic                       x_lt, x_gt, y_lt, y_gt;
  logic [scgr_pkg::TS_W-1:0]  shift;
  logic [scgr_pkg::TW-1:0]    tile, fx, fy;
  logic                       behind, vertical;

  always_comb begin
    // coordinates trimmed to the used width
    xs = src_x[scgr_pkg::CRD_W-1:0];
    ys = src_y[scgr_pkg::CRD_W-1:0];
    xt = tgt_x[scgr_pkg::CRD_W-1:0];
    yt = tgt_y[scgr_pkg::CRD_W-1:0];
    x_lt = xs < xt;
    x_gt = xs > xt;
    y_lt = ys < yt;
    y_gt = ys > yt;

    // tile size and distance to the first boundary on each axis
    shift = (tile_shift < scgr_pkg::TS_W'(scgr_pkg::MIN_SHIFT)) ?
            scgr_pkg::TS_W'(scgr_pkg::MIN_SHIFT) : tile_shift;
    tile  = scgr_pkg::TW'(1) << shift;
    fx    = scgr_pkg::TW'(xs) & (tile - 1'b1);
    fy    = scgr_pkg::TW'(ys) & (tile - 1'b1);

    // facing and vertical rejects
    behind   = facing_left ? x_lt : x_gt;
    vertical = !x_lt && !x_gt && (y_lt || y_gt);

    req              = '0;
    req.is_query     = (cmd == scgr_pkg::CMD_QUERY);
    req.wr_ok        = (int'(cell_col) < scgr_pkg::GRID_COLS) &&
                       (int'(cell_row) < scgr_pkg::GRID_ROWS);
    req.wr_occ       = occupied;
    req.wr_col       = scgr_pkg::COL_AW'(cell_col);
    req.wr_row       = scgr_pkg::ROW_AW'(cell_row);
    req.early        = behind || vertical;
    req.early_status = behind ? scgr_pkg::ST_BEHIND : scgr_pkg::ST_OUTCONE;
    req.need_cone    = x_lt || x_gt;
    req.dy           = {1'b0, yt} - {1'b0, ys};
    req.adx          = x_lt ? (xt - xs) : (xs - xt);
    req.ady          = y_lt ? (yt - ys) : (ys - yt);
    req.x_neg        = x_gt;
    req.y_neg        = y_gt;
    req.i0           = scgr_pkg::CI_W'(xs >> shift);
    req.j0           = scgr_pkg::CI_W'(ys >> shift);
    req.iend         = scgr_pkg::CI_W'(xt >> shift);
    req.jend         = scgr_pkg::CI_W'(yt >> shift);
    req.ax0          = x_lt ? scgr_pkg::AX0_W'(tile - fx) : scgr_pkg::AX0_W'(fx);
    req.ay0          = y_lt ? scgr_pkg::AX0_W'(tile - fy) : scgr_pkg::AX0_W'(fy);
    req.shift        = shift;
  end

endmodule

### design/scgr_queue.sv
// ----------------------------------------------------------------------------
// scgr_queue
// Short request queue between the classifying front and the executing back.
// ----------------------------------------------------------------------------
module scgr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  scgr_pkg::req_t push_req,
  output logic           full,
  input  logic           pop,
  output scgr_pkg::req_t head,
  output logic           empty
);

  scgr_pkg::req_t            entry_r [scgr_pkg::QDEPTH];
  logic [scgr_pkg::QA_W-1:0] wptr_r, rptr_r;
  logic [scgr_pkg::QA_W:0]   cnt_r;
  logic                      do_push, do_pop;

  assign full    = (cnt_r == (scgr_pkg::QA_W+1)'(scgr_pkg::QDEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rptr_r];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == scgr_pkg::QA_W'(scgr_pkg::QDEPTH-1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == scgr_pkg::QA_W'(scgr_pkg::QDEPTH-1)) ? '0 : rptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wptr_r] <= push_req;
    end
  end

endmodule

### design/scgr_back.sv
// ----------------------------------------------------------------------------
// scgr_back
// Executes queued requests: grid row updates, cone test and the cell walk.
// ----------------------------------------------------------------------------
module scgr_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  scgr_pkg::req_t                      q_head,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic signed [scgr_pkg::TAN_W-1:0]   tan_low,
  input  logic signed [scgr_pkg::TAN_W-1:0]   tan_high,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_visible,
  output logic [1:0]                          out_status
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_WWR,
    S_MLO,
    S_MHI,
    S_CCHK,
    S_MX,
    S_MY,
    S_MEND,
    S_WALK,
    S_OUT
  } state_t;

  state_t                               state_r;
  scgr_pkg::req_t                       req_r;
  scgr_pkg::status_t                    res_r;
  scgr_pkg::status_t                    out_status_r;
  logic                                 out_valid_r;
  logic                                 lo_fail_r;
  logic signed [scgr_pkg::MP_W-1:0]     prod_r;
  logic [scgr_pkg::PROD_W-1:0]          px_r, py_r;
  logic [scgr_pkg::CI_W-1:0]            i_r, j_r;
  logic [scgr_pkg::GRID_ROWS-1:0]       row_valid_r;

  // grid rows
  logic [scgr_pkg::GRID_COLS-1:0]       grid_mem [scgr_pkg::GRID_ROWS];
  logic [scgr_pkg::GRID_COLS-1:0]       rd_row_r;
  logic                                 row_hit_r;
  logic [scgr_pkg::ROW_AW-1:0]          rd_addr;
  logic                                 rd_in;
  logic                                 mem_we;
  logic [scgr_pkg::GRID_COLS-1:0]       wr_data;

  logic signed [scgr_pkg::MA_W-1:0]     ma;
  logic signed [scgr_pkg::MB_W-1:0]     mb;
  logic signed [scgr_pkg::MP_W-1:0]     dy256_x;
  logic                                 cell_full, stepx, done_x, done_y;
  logic [scgr_pkg::CI_W-1:0]            i_step, j_step, j_nxt;

  assign q_pop       = (state_r == S_IDLE) && !q_empty;
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_visible = (out_status_r == scgr_pkg::ST_SEEN);
  assign dy256_x     = scgr_pkg::MP_W'($signed({req_r.dy, {scgr_pkg::TAN_FRAC{1'b0}}}));

  // shared multiplier operand select
  always_comb begin
    unique case (state_r)
      S_MLO: begin
        ma = scgr_pkg::MA_W'(tan_low);
        mb = $signed({1'b0, req_r.adx});
      end
      S_MHI: begin
        ma = scgr_pkg::MA_W'(tan_high);
        mb = $signed({1'b0, req_r.adx});
      end
      S_MX: begin
        ma = scgr_pkg::MA_W'({1'b0, req_r.ax0});
        mb = $signed({1'b0, req_r.ady});
      end
      S_MY: begin
        ma = scgr_pkg::MA_W'({1'b0, req_r.ay0});
        mb = $signed({1'b0, req_r.adx});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // walk step decision for the current cell
  always_comb begin
    cell_full = row_hit_r && (int'(i_r) < scgr_pkg::GRID_COLS) &&
                rd_row_r[scgr_pkg::COL_AW'(i_r)];
    if (req_r.adx == '0) begin
      stepx = (req_r.ady == '0);
    end else begin
      stepx = (req_r.ady == '0) || (px_r <= py_r);
    end
    done_x = stepx && (i_r == req_r.iend);
    done_y = !stepx && (j_r == req_r.jend);
    i_step = req_r.x_neg ? i_r - 1'b1 : i_r + 1'b1;
    j_step = req_r.y_neg ? j_r - 1'b1 : j_r + 1'b1;
    j_nxt  = stepx ? j_r : j_step;
  end

  // row read address
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        rd_addr = q_head.wr_row;
        rd_in   = 1'b1;
      end
      S_MEND: begin
        rd_addr = scgr_pkg::ROW_AW'(req_r.j0);
        rd_in   = (int'(req_r.j0) < scgr_pkg::GRID_ROWS);
      end
      default: begin
        rd_addr = scgr_pkg::ROW_AW'(j_nxt);
        rd_in   = (int'(j_nxt) < scgr_pkg::GRID_ROWS);
      end
    endcase
  end

  // row merge for a cell write, a row never written reads as clear
  always_comb begin
    mem_we  = (state_r == S_WWR);
    wr_data = row_hit_r ? rd_row_r : '0;
    wr_data[req_r.wr_col] = req_r.wr_occ;
  end

  // grid memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[req_r.wr_row] <= wr_data;
    end
    rd_row_r <= grid_mem[rd_addr];
  end

  // sequencer with registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      out_status_r <= scgr_pkg::ST_SEEN;
      row_valid_r  <= '0;
      row_hit_r    <= 1'b0;
    end else begin
      row_hit_r <= rd_in && row_valid_r[rd_addr];
      // result taken, the result state reloads the register itself
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      prod_r <= ma * mb;

      unique case (state_r)
        S_IDLE: begin
          if (!q_empty) begin
            req_r <= q_head;
            if (!q_head.is_query) begin
              state_r <= q_head.wr_ok ? S_WWR : S_IDLE;
            end else if (q_head.early) begin
              res_r   <= q_head.early_status;
              state_r <= S_OUT;
            end else begin
              state_r <= q_head.need_cone ? S_MLO : S_MX;
            end
          end
        end
        S_WWR: begin
          row_valid_r[req_r.wr_row] <= 1'b1;
          state_r <= S_IDLE;
        end
        S_MLO: begin
          state_r <= S_MHI;
        end
        S_MHI: begin
          lo_fail_r <= (dy256_x < prod_r);
          state_r   <= S_CCHK;
        end
        S_CCHK: begin
          if (lo_fail_r || (dy256_x > prod_r)) begin
            res_r   <= scgr_pkg::ST_OUTCONE;
            state_r <= S_OUT;
          end else begin
            state_r <= S_MX;
          end
        end
        S_MX: begin
          state_r <= S_MY;
        end
        S_MY: begin
          px_r    <= scgr_pkg::PROD_W'(prod_r);
          state_r <= S_MEND;
        end
        S_MEND: begin
          py_r    <= scgr_pkg::PROD_W'(prod_r);
          i_r     <= req_r.i0;
          j_r     <= req_r.j0;
          state_r <= S_WALK;
        end
        S_WALK: begin
          if (cell_full) begin
            res_r   <= scgr_pkg::ST_BLOCKED;
            state_r <= S_OUT;
          end else if (done_x || done_y) begin
            res_r   <= scgr_pkg::ST_SEEN;
            state_r <= S_OUT;
          end else if (stepx) begin
            i_r  <= i_step;
            px_r <= px_r + (scgr_pkg::PROD_W'(req_r.ady) << req_r.shift);
          end else begin
            j_r  <= j_step;
            py_r <= py_r + (scgr_pkg::PROD_W'(req_r.adx) << req_r.shift);
          end
        end
        S_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sight cone grid ray check. Random cell writes
// and line-of-sight requests go in under several tile and cone settings; a
// scoreboard keeps its own grid and register copy and predicts each view.
// ----------------------------------------------------------------------------
module tb_top;
  import scgr_pkg::*;

  localparam int WATCHDOG_LIMIT  = 40000;
  localparam int HOLD_CYCLES     = 400;
  localparam int SETTLE_CYCLES   = 30;
  localparam int ITEMS_PER_PHASE = 285;
  localparam int NUM_PHASES      = 7;

  // one request as seen on the input ports
  typedef struct packed {
    logic                cmd;
    logic [CELL_W-1:0]   col;
    logic [CELL_W-1:0]   row;
    logic                occ;
    logic [CRD_IN_W-1:0] sx;
    logic [CRD_IN_W-1:0] sy;
    logic [CRD_IN_W-1:0] tx;
    logic [CRD_IN_W-1:0] ty;
    logic                fl;
  } probe_t;

  // one predicted result
  typedef struct {
    logic    visible;
    status_t status;
  } view_t;

  // grid shadow, register shadow and the queue of predicted views
  class los_scoreboard;
    bit         grid [GRID_ROWS][GRID_COLS];
    bit [3:0]   tile_shift_r;
    longint     tan_lo;
    longint     tan_hi;
    view_t      pending_views [$];
    int         errors;

    function new();
      tile_shift_r = TILE_SHIFT_RST;
      tan_lo       = longint'(TAN_LOW_RST);
      tan_hi       = longint'(TAN_HIGH_RST);
      errors       = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TILE_SHIFT: tile_shift_r = data[TS_W-1:0];
        CFG_TAN_LOW:    tan_lo = longint'($signed(data[TAN_W-1:0]));
        CFG_TAN_HIGH:   tan_hi = longint'($signed(data[TAN_W-1:0]));
        default: ;
      endcase
    endfunction

    function int eff_shift();
      return (tile_shift_r < MIN_SHIFT) ? MIN_SHIFT : int'(tile_shift_r);
    endfunction

    // cells off the grid read as empty
    function bit cell_set(longint i, longint j);
      if (i < 0 || j < 0 || i >= GRID_COLS || j >= GRID_ROWS) return 1'b0;
      return grid[j][i];
    endfunction

    // cell walk along the segment; x step first on a corner crossing
    function bit path_clear(longint x1, longint y1, longint x2, longint y2);
      longint s, t, adx, ady, i, j, iend, jend, di, dj, ax, ay;
      bit     stepx;
      s    = eff_shift();
      t    = longint'(1) << s;
      adx  = (x1 < x2) ? x2 - x1 : x1 - x2;
      ady  = (y1 < y2) ? y2 - y1 : y1 - y2;
      i    = x1 >> s;
      j    = y1 >> s;
      iend = x2 >> s;
      jend = y2 >> s;
      di   = (x1 < x2) ? 1 : ((x1 > x2) ? -1 : 0);
      dj   = (y1 < y2) ? 1 : ((y1 > y2) ? -1 : 0);
      ax   = (x1 < x2) ? t - (x1 & (t - 1)) : (x1 & (t - 1));
      ay   = (y1 < y2) ? t - (y1 & (t - 1)) : (y1 & (t - 1));
      while (1) begin
        if (cell_set(i, j)) return 1'b0;
        if (adx == 0) stepx = (ady == 0);
        else stepx = (ady == 0) || (ax * ady <= ay * adx);
        if (stepx) begin
          if (i == iend) return 1'b1;
          ax += t;
          i  += di;
        end else begin
          if (j == jend) return 1'b1;
          ay += t;
          j  += dj;
        end
      end
    endfunction

    // apply a write, or predict the view for a query
    function void note_request(probe_t r);
      longint  x1, y1, x2, y2, dx, dy, adx, dys;
      status_t st;
      view_t   v;
      if (r.cmd == CMD_WRITE) begin
        if (r.col < GRID_COLS && r.row < GRID_ROWS) grid[r.row][r.col] = r.occ;
        return;
      end
      x1  = longint'(r.sx[CRD_W-1:0]);
      y1  = longint'(r.sy[CRD_W-1:0]);
      x2  = longint'(r.tx[CRD_W-1:0]);
      y2  = longint'(r.ty[CRD_W-1:0]);
      dx  = x2 - x1;
      dy  = y2 - y1;
      adx = (dx < 0) ? -dx : dx;
      dys = dy * (longint'(1) << TAN_FRAC);
      if (r.fl ? (dx > 0) : (dx < 0)) st = ST_BEHIND;
      else if (dx == 0 && dy != 0) st = ST_OUTCONE;
      else if (dx != 0 && (dys < tan_lo * adx || dys > tan_hi * adx)) st = ST_OUTCONE;
      else st = path_clear(x1, y1, x2, y2) ? ST_SEEN : ST_BLOCKED;
      v.visible = (st == ST_SEEN);
      v.status  = st;
      pending_views.push_back(v);
    endfunction

    function void check_result(logic vis, logic [1:0] st);
      view_t want;
      if (pending_views.size() == 0) begin
        $display("%0t: result with no query pending, visible %0b status %0d",
                 $time, vis, st);
        errors++;
        return;
      end
      want = pending_views.pop_front();
      if (vis !== want.visible) begin
        $display("%0t: visible mismatch, expected %0b actual %0b",
                 $time, want.visible, vis);
        errors++;
      end
      if (st !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, st);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic                  in_cmd;
  logic [CELL_W-1:0]     in_cell_col;
  logic [CELL_W-1:0]     in_cell_row;
  logic                  in_occupied;
  logic [CRD_IN_W-1:0]   in_src_x;
  logic [CRD_IN_W-1:0]   in_src_y;
  logic [CRD_IN_W-1:0]   in_tgt_x;
  logic [CRD_IN_W-1:0]   in_tgt_y;
  logic                  in_facing_left;
  logic                  out_valid;
  logic                  out_stall;
  logic                  out_visible;
  logic [1:0]            out_status;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  los_scoreboard sb = new;
  probe_t        taken;
  bit            quiet_tail = 1'b0;
  bit            hold_request = 1'b0;
  int            hold_left = 0;
  int            stall_left = 0;
  int            rx_cycle = 0;
  int            idle_cycles = 0;

  sight_cone_grid_ray_check_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_cell_col    (in_cell_col),
    .in_cell_row    (in_cell_row),
    .in_occupied    (in_occupied),
    .in_src_x       (in_src_x),
    .in_src_y       (in_src_y),
    .in_tgt_x       (in_tgt_x),
    .in_tgt_y       (in_tgt_y),
    .in_facing_left (in_facing_left),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_visible    (out_visible),
    .out_status     (out_status),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // accepted requests feed the scoreboard, accepted results get checked
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      taken.cmd = in_cmd;
      taken.col = in_cell_col;
      taken.row = in_cell_row;
      taken.occ = in_occupied;
      taken.sx  = in_src_x;
      taken.sy  = in_src_y;
      taken.tx  = in_tgt_x;
      taken.ty  = in_tgt_y;
      taken.fl  = in_facing_left;
      sb.note_request(taken);
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_visible, out_status);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: long hold on request, random stall bursts, calm stretches
  always @(negedge clk) begin
    rx_cycle++;
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && ((rx_cycle / 300) % 3) != 0 && $urandom_range(0, 3) == 0) begin
      stall_left = int'($urandom_range(1, 5)) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // random filler for the fields a request does not use
  function automatic probe_t random_probe();
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    return probe_t'(raw[$bits(probe_t)-1:0]);
  endfunction

  // present one request and hold it until taken
  task automatic send_request(probe_t r);
    @(negedge clk);
    in_valid       <= 1'b1;
    in_cmd         <= r.cmd;
    in_cell_col    <= r.col;
    in_cell_row    <= r.row;
    in_occupied    <= r.occ;
    in_src_x       <= r.sx;
    in_src_y       <= r.sy;
    in_tgt_x       <= r.tx;
    in_tgt_y       <= r.ty;
    in_facing_left <= r.fl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_requests(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_write(int col, int row, bit occ);
    probe_t r;
    r     = random_probe();
    r.cmd = CMD_WRITE;
    r.col = CELL_W'(col);
    r.row = CELL_W'(row);
    r.occ = occ;
    send_request(r);
  endtask

  task automatic send_query(int sx, int sy, int tx, int ty, bit fl);
    probe_t r;
    r     = random_probe();
    r.cmd = CMD_QUERY;
    r.sx  = CRD_IN_W'(sx);
    r.sy  = CRD_IN_W'(sy);
    r.tx  = CRD_IN_W'(tx);
    r.ty  = CRD_IN_W'(ty);
    r.fl  = fl;
    send_request(r);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drop valid, wait for every predicted view, then let trailing writes finish
  task automatic settle_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_views.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic longint clamp_crd(longint v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  // cell write biased toward the cells the current tile size can reach
  function automatic probe_t random_write();
    probe_t r;
    longint cells;
    r     = random_probe();
    cells = longint'(65536) >> sb.eff_shift();
    if (cells > GRID_COLS) cells = GRID_COLS;
    r.cmd = CMD_WRITE;
    if ($urandom_range(0, 4) != 0) begin
      r.col = CELL_W'($urandom_range(0, 32'(cells - 1)));
      r.row = CELL_W'($urandom_range(0, 32'(cells - 1)));
    end
    r.occ = ($urandom_range(0, 99) < 30);
    return r;
  endfunction

  // query near the grid: short reach, slope drawn around the cone bounds
  function automatic probe_t random_query();
    probe_t r;
    longint s, span, adx, dy, k, sx, sy, cap;
    bit     go_left;
    r     = random_probe();
    r.cmd = CMD_QUERY;
    s     = sb.eff_shift();
    span  = longint'(GRID_COLS) << s;
    if (span > 65536) span = 65536;
    // occasional full-range segment, rarer when tiles are small
    if ($urandom_range(0, 99) < ((s >= 8) ? 4 : 1)) return r;
    sx = longint'($urandom_range(0, 32'(span - 1)));
    sy = longint'($urandom_range(0, 32'(span - 1)));
    if ($urandom_range(0, 19) == 0) adx = 0;
    else adx = longint'($urandom_range(1, ($urandom_range(1, 4)) << s));
    if (sb.tan_lo <= sb.tan_hi)
      k = sb.tan_lo + longint'($urandom_range(0, 32'(sb.tan_hi - sb.tan_lo)));
    else k = longint'($urandom_range(0, 1024)) - 512;
    if ($urandom_range(0, 3) == 0) k += longint'($urandom_range(0, 64)) - 32;
    dy = (k * adx) / (longint'(1) << TAN_FRAC);
    if ($urandom_range(0, 3) == 0) dy += longint'($urandom_range(0, 2)) - 1;
    // vertical offsets and the same point
    if (adx == 0 && $urandom_range(0, 1) == 1)
      dy = longint'($urandom_range(0, 2 << s)) - (longint'(1) << s);
    cap = longint'(6) << s;
    if (dy > cap) dy = cap;
    if (dy < -cap) dy = -cap;
    go_left = 1'($urandom_range(0, 1));
    r.fl = ($urandom_range(0, 9) == 0) ? !go_left : go_left;
    r.sx = CRD_IN_W'(sx);
    r.sy = CRD_IN_W'(sy);
    r.tx = CRD_IN_W'(clamp_crd(go_left ? sx - adx : sx + adx));
    r.ty = CRD_IN_W'(clamp_crd(sy + dy));
    return r;
  endfunction

  // main sequence
  initial begin
    bit [3:0]  plan_ts [NUM_PHASES] = '{4'd9, 4'd4, 4'd15, 4'd0, 4'd12, 4'd9, 4'd6};
    bit [15:0] plan_lo [NUM_PHASES] = '{16'hff00, 16'h8000, 16'h7fff, 16'h0000,
                                        16'hfc00, 16'h0000, 16'hff00};
    bit [15:0] plan_hi [NUM_PHASES] = '{16'h0100, 16'h7fff, 16'h8000, 16'h0200,
                                        16'hffc0, 16'h0000, 16'h0100};
    bit [15:0] tmp;
    bit        calm;

    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_cmd         = CMD_WRITE;
    in_cell_col    = '0;
    in_cell_row    = '0;
    in_occupied    = 1'b0;
    in_src_x       = '0;
    in_src_y       = '0;
    in_tgt_x       = '0;
    in_tgt_y       = '0;
    in_facing_left = 1'b0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_index      = CFG_TILE_SHIFT;
    cfg_data       = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed requests under reset settings (512-unit tiles, slope -1..1)
    send_query(1000, 1000, 1000, 1000, 1'b0);
    send_query(1000, 1000, 1000, 1000, 1'b1);
    send_write(0, 0, 1'b1);
    send_query(100, 100, 100, 100, 1'b1);
    send_query(0, 0, 65535, 65535, 1'b0);
    send_write(0, 0, 1'b0);
    send_query(0, 0, 65535, 65535, 1'b0);
    send_query(65535, 65535, 0, 0, 1'b1);
    // target behind the facing direction
    send_query(5000, 5000, 4000, 5000, 1'b0);
    send_query(4000, 5000, 5000, 5000, 1'b1);
    // vertical offsets, then just outside and just inside the cone
    send_query(3000, 1000, 3000, 2000, 1'b0);
    send_query(3000, 2000, 3000, 1000, 1'b1);
    send_query(1000, 1000, 2000, 2001, 1'b0);
    send_query(2000, 1000, 1000, 1999, 1'b1);
    // far corner cell of the grid
    send_write(63, 63, 1'b1);
    send_query(32300, 32300, 32700, 32400, 1'b0);
    send_write(63, 63, 1'b0);
    // corner crossing takes the x step first
    send_write(1, 0, 1'b1);
    send_query(256, 256, 768, 768, 1'b0);
    send_write(1, 0, 1'b0);
    send_write(0, 1, 1'b1);
    send_query(256, 256, 768, 768, 1'b0);
    send_write(0, 1, 1'b0);
    // segment entirely off the grid
    send_query(40000, 100, 60000, 300, 1'b0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != 0) begin
        settle_block();
        if (p == 5) begin
          plan_ts[p] = 4'($urandom_range(4, 15));
          plan_lo[p] = 16'($urandom);
          plan_hi[p] = 16'($urandom);
          if ($signed(plan_lo[p]) > $signed(plan_hi[p]) && $urandom_range(0, 3) != 0) begin
            tmp        = plan_lo[p];
            plan_lo[p] = plan_hi[p];
            plan_hi[p] = tmp;
          end
        end
        write_reg(CFG_TILE_SHIFT, {12'd0, plan_ts[p]});
        write_reg(CFG_TAN_LOW, plan_lo[p]);
        write_reg(CFG_TAN_HIGH, plan_hi[p]);
      end
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // long result hold while requests keep coming
        if (p == 1 && n == 40) hold_request = 1'b1;
        if ($urandom_range(0, 9) < 3) send_request(random_write());
        else send_request(random_query());
        calm = ((n / 40) % 3) == 0;
        if (!quiet_tail && !calm && $urandom_range(0, 4) == 0)
          pause_requests(int'($urandom_range(1, 5)));
      end
    end
    settle_block();

    if (sb.errors == 0 && sb.pending_views.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
